FILE: rtl/core/vprf_pkg.sv
// types, constants and helpers shared by the vertical pixel ratio filter
// no dependencies
package vprf_pkg;

    localparam int PIX_W          = 16;
    localparam int RATIO_W        = 8;
    localparam int CFG_W          = 11;
    localparam int GAIN           = 10;
    localparam int WIDTH_RESET    = 640;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_ROW_OFFSET = 8;
    localparam int DIV_BITS       = 2;
    localparam int DIV_STAGES     = PIX_W / DIV_BITS;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_vprf_in;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               row_end;
    } t_vprf_out;

    typedef struct packed {
        logic [PIX_W-1:0] num;
        logic [PIX_W-1:0] den;
        logic             row_end;
    } t_vprf_div;

    // zero acts as one, oversize acts as the line store width
    function automatic int unsigned clamp_width(int unsigned w, int unsigned max_w);
        int unsigned res;
        res = w;
        if (w == 0) begin
            res = 1;
        end else if (w > max_w) begin
            res = max_w;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/vprf_divider.sv
// pipelined restoring divider, two quotient bits per stage, with elastic stalls
// depends on vprf_pkg
module vprf_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  vprf_pkg::t_vprf_div i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output vprf_pkg::t_vprf_out o_res
);
    import vprf_pkg::*;

    logic [DIV_STAGES-1:0] r_v;
    logic [PIX_W-1:0]      r_n [DIV_STAGES];
    logic [PIX_W-1:0]      r_r [DIV_STAGES];
    logic [PIX_W-1:0]      r_d [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_e;
    logic [DIV_STAGES-1:0] w_rdy;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [PIX_W-1:0] w_n_in;
        logic [PIX_W-1:0] w_r_in;
        logic [PIX_W-1:0] w_d_in;
        logic             w_e_in;
        logic             w_v_in;
        logic             w_next_rdy;
        logic [PIX_W-1:0] n_n;
        logic [PIX_W-1:0] n_r;

        if (s == 0) begin : g_first
            assign w_n_in = i_req.num;
            assign w_r_in = '0;
            assign w_d_in = i_req.den;
            assign w_e_in = i_req.row_end;
            assign w_v_in = i_valid;
        end else begin : g_mid
            assign w_n_in = r_n[s-1];
            assign w_r_in = r_r[s-1];
            assign w_d_in = r_d[s-1];
            assign w_e_in = r_e[s-1];
            assign w_v_in = r_v[s-1];
        end

        if (s == DIV_STAGES - 1) begin : g_last
            assign w_next_rdy = !i_stall;
        end else begin : g_inner
            assign w_next_rdy = w_rdy[s+1];
        end

        assign w_rdy[s] = !r_v[s] || w_next_rdy;

        always_comb begin
            logic [PIX_W:0]   rs;
            logic [PIX_W-1:0] nt;
            logic [PIX_W-1:0] rt;
            nt = w_n_in;
            rt = w_r_in;
            for (int b = 0; b < DIV_BITS; b++) begin
                rs = {rt, nt[PIX_W-1]};
                nt = {nt[PIX_W-2:0], 1'b0};
                if (rs >= {1'b0, w_d_in}) begin
                    rs    = rs - {1'b0, w_d_in};
                    nt[0] = 1'b1;
                end
                rt = rs[PIX_W-1:0];
            end
            n_n = nt;
            n_r = rt;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_v[s] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_n[s] <= n_n;
                r_r[s] <= n_r;
                r_d[s] <= w_d_in;
                r_e[s] <= w_e_in;
            end
        end
    end

    assign o_ready       = w_rdy[0];
    assign o_valid       = r_v[DIV_STAGES-1];
    assign o_res.ratio   = r_n[DIV_STAGES-1][RATIO_W-1:0];
    assign o_res.row_end = r_e[DIV_STAGES-1];

endmodule

FILE: rtl/core/vertical_pixel_ratio_filter.sv
// vertical pixel ratio filter: ratio of each pixel to the pixel eight rows above
// a request is registered together with its ring read, then passes the 8 divider stages
// throughput: one request per cycle unless the output stalls, set by the ring memory's one read and one write port
// reset: clears row/column position, valid flags, width back to 640; ring contents kept
// depends on vprf_pkg, vprf_divider
module vertical_pixel_ratio_filter #(
    parameter int MAX_WIDTH  = vprf_pkg::DEF_MAX_WIDTH,
    parameter int ROW_OFFSET = vprf_pkg::DEF_ROW_OFFSET
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  vprf_pkg::t_vprf_in          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output vprf_pkg::t_vprf_out         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vprf_pkg::CFG_W-1:0]  i_cfg_data
);
    import vprf_pkg::*;

    localparam int DEPTH = ROW_OFFSET * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = (ROW_OFFSET > 1) ? $clog2(ROW_OFFSET) : 1;
    localparam int EW0   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (CFG_W > EW0) ? CFG_W : EW0;

    logic [PIX_W-1:0] r_ring [DEPTH];

    logic [CMPW-1:0]  r_eff;
    logic [CW-1:0]    r_col;
    logic [SW-1:0]    r_slot;
    logic             r_past;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_self;
    logic             r_s1_end;
    logic [PIX_W-1:0] r_rdata;

    logic             w_accept;
    logic             w_s1_rdy;
    logic             w_div_rdy;
    logic [CW-1:0]    w_col;
    logic [SW-1:0]    w_slot;
    logic             w_past;
    logic             w_last;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic [CW-1:0]    n_col;
    logic [SW-1:0]    n_slot;
    logic             n_past;
    logic [PIX_W-1:0] w_ref;
    t_vprf_div        w_div_req;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff <= CMPW'(clamp_width(WIDTH_RESET, MAX_WIDTH));
        end else if (i_cfg_valid) begin
            r_eff <= CMPW'(clamp_width(32'(i_cfg_data), MAX_WIDTH));
        end
    end

    // position tracking
    assign w_s1_rdy   = !r_s1_valid || w_div_rdy;
    assign o_in_stall = !w_s1_rdy;
    assign w_accept   = i_in_valid && w_s1_rdy;

    always_comb begin
        w_col   = i_in_data.frame_start ? '0 : r_col;
        w_slot  = i_in_data.frame_start ? '0 : r_slot;
        w_past  = i_in_data.frame_start ? 1'b0 : r_past;
        w_waddr = AW'(w_slot * MAX_WIDTH + w_col);
        w_raddr = w_past ? w_waddr : AW'(w_col);
        w_last  = (CMPW'(w_col) + CMPW'(1)) >= r_eff;
        n_col   = w_col;
        n_slot  = w_slot;
        n_past  = w_past;
        if (w_last) begin
            n_col = '0;
            if (int'(w_slot) + 1 >= ROW_OFFSET) begin
                n_slot = '0;
                n_past = 1'b1;
            end else begin
                n_slot = w_slot + SW'(1);
            end
        end else begin
            n_col = w_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_slot <= '0;
            r_past <= 1'b0;
        end else if (w_accept) begin
            r_col  <= n_col;
            r_slot <= n_slot;
            r_past <= n_past;
        end
    end

    // ring line store, read before write at the same address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata         <= r_ring[w_raddr];
            r_ring[w_waddr] <= i_in_data.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix  <= i_in_data.pixel;
            r_s1_self <= !w_past && (w_slot == '0);
            r_s1_end  <= w_last;
        end
    end

    // zero reference forced to a zero quotient
    always_comb begin
        w_ref             = r_s1_self ? r_s1_pix : r_rdata;
        w_div_req.row_end = r_s1_end;
        if (w_ref == '0) begin
            w_div_req.num = '0;
            w_div_req.den = PIX_W'(1);
        end else begin
            w_div_req.num = PIX_W'(r_s1_pix * GAIN);
            w_div_req.den = w_ref;
        end
    end

    vprf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (w_div_rdy),
        .i_req   (w_div_req),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (o_out_data)
    );

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_slot) < ROW_OFFSET)
        else $error("row slot out of range");

    a_past_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_in_data.frame_start && r_past |=> r_past)
        else $error("past-top flag dropped within a frame");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_div_rdy |=> r_s1_valid && $stable(r_rdata) && $stable(r_s1_pix))
        else $error("held ring read lost during stall");

endmodule

FILE: verif/vprf_checker.sv
`timescale 1ns / 100ps
// checker for the vertical pixel ratio filter: tracks requests, predicts each ratio
// from its own line store copy and compares every accepted result; depends on vprf_pkg
module vprf_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  vprf_pkg::t_vprf_in         i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  vprf_pkg::t_vprf_out        i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [vprf_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    import vprf_pkg::*;

    localparam int STORE_DEPTH = DEF_ROW_OFFSET * DEF_MAX_WIDTH;

    logic [PIX_W-1:0] line_store [STORE_DEPTH];
    logic [CFG_W-1:0] width_reg;
    int unsigned      next_col;
    int unsigned      next_row;
    logic             above_top;
    t_vprf_out        ratios_q[$];
    int               fails;
    int               checked;

    function automatic t_vprf_out predict_ratio(t_vprf_in req);
        int unsigned      row_len;
        int unsigned      col;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] scaled;
        t_vprf_out        res;
        if (width_reg == 0) begin
            row_len = 1;
        end else if (width_reg > DEF_MAX_WIDTH) begin
            row_len = DEF_MAX_WIDTH;
        end else begin
            row_len = width_reg;
        end
        if (req.frame_start) begin
            next_col  = 0;
            next_row  = 0;
            above_top = 1'b0;
        end
        col = (next_col >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : next_col;
        // top-edge clamp: row 0 of the frame stands in until eight rows are done
        if (above_top) begin
            above = line_store[next_row * DEF_MAX_WIDTH + col];
        end else if (next_row == 0) begin
            above = req.pixel;
        end else begin
            above = line_store[col];
        end
        line_store[next_row * DEF_MAX_WIDTH + col] = req.pixel;
        scaled      = PIX_W'(req.pixel * GAIN);
        res.ratio   = (above == 0) ? '0 : RATIO_W'(scaled / above);
        res.row_end = (col + 1 >= row_len);
        if (res.row_end) begin
            next_col = 0;
            if (next_row + 1 >= DEF_ROW_OFFSET) begin
                next_row  = 0;
                above_top = 1'b1;
            end else begin
                next_row++;
            end
        end else begin
            next_col = col + 1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_vprf_out want;
        if (!i_rst_n) begin
            width_reg = CFG_W'(WIDTH_RESET);
            next_col  = 0;
            next_row  = 0;
            above_top = 1'b0;
            ratios_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (ratios_q.size() == 0) begin
                    $error("result with no request pending: ratio %0d row_end %0b",
                           i_out_data.ratio, i_out_data.row_end);
                    fails++;
                end else begin
                    want = ratios_q.pop_front();
                    checked++;
                    if (want.ratio !== i_out_data.ratio) begin
                        $error("ratio mismatch: expected %0d, actual %0d",
                               want.ratio, i_out_data.ratio);
                        fails++;
                    end
                    if (want.row_end !== i_out_data.row_end) begin
                        $error("row_end mismatch: expected %0b, actual %0b",
                               want.row_end, i_out_data.row_end);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ratios_q.push_back(predict_ratio(i_in_data));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                width_reg = i_cfg_data;
            end
        end
        o_pending    <= ratios_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

FILE: verif/vertical_pixel_ratio_filter_test.sv
`timescale 1ns / 100ps
// top of the vertical pixel ratio filter testbench: clock, reset, pixel and width stimulus,
// output stall patterns and the verdict; depends on vprf_pkg, vprf_checker and the block
module vertical_pixel_ratio_filter_test;
    import vprf_pkg::*;

    localparam int RUN_LIMIT      = 400000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int STALL_NONE     = 0;
    localparam int STALL_HALF     = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_vprf_in         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_stall;
    logic             out_valid;
    t_vprf_out        out_data;
    logic             cfg_ready;
    int               fail_total;
    int               pending;
    int               checked;

    int               burst_left   = 0;
    int               sent_count   = 0;
    int               width_writes = 0;
    int unsigned      cur_span     = WIDTH_RESET;
    logic             need_frame   = 1'b1;

    vertical_pixel_ratio_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    vprf_checker ratio_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_total),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] p;
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            2, 3: p = PIX_W'($urandom_range(1, 63));
            4: p = PIX_W'($urandom_range(6550, 6560));
            default: p = PIX_W'($urandom);
        endcase
        return p;
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_data  <= '{pixel: pix, frame_start: fs};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] w);
        int unsigned span;
        if (w == 0) begin
            span = 1;
        end else if (w > DEF_MAX_WIDTH) begin
            span = DEF_MAX_WIDTH;
        end else begin
            span = w;
        end
        drain_results();
        // idle gap before the register write
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        // wider rows would read line store entries not yet written in this frame
        if (span > cur_span) begin
            need_frame = 1'b1;
        end
        cur_span = span;
        width_writes++;
    endtask

    task automatic stream_rows(input int n, input logic may_restart);
        logic fs;
        for (int i = 0; i < n; i++) begin
            fs = need_frame || (may_restart && $urandom_range(0, 149) == 0);
            need_frame = 1'b0;
            push_pixel(pick_pixel(), fs);
        end
    endtask

    initial begin : receiver
        int hold;
        int mode;
        int span;
        while (!rst_n) @(posedge clk);
        repeat ($urandom_range(30, 60)) begin
            out_stall <= ($urandom_range(0, 3) == 0);
            @(posedge clk);
        end
        // long hold so the pipeline fills and pushes back on requests
        hold = 0;
        while (hold < 300) begin
            out_stall <= 1'b1;
            @(posedge clk);
            hold++;
        end
        forever begin
            mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            span = $urandom_range(10, 80);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_HALF: out_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (k % 3 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int rand_count;
        int n;
        logic [CFG_W-1:0] w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // row 0 at reset width: each pixel is its own reference
        push_pixel(16'h0000, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h0001, 1'b0);
        push_pixel(16'd6553, 1'b0);
        push_pixel(16'd6554, 1'b0);
        push_pixel(16'd13107, 1'b0);
        push_pixel(16'hAAAA, 1'b0);
        push_pixel(16'h5555, 1'b0);
        push_pixel(16'd10, 1'b0);
        push_pixel(16'd777, 1'b1);
        need_frame = 1'b0;
        stream_rows(639, 1'b0);

        // zero register acts as one pixel per row
        write_width('0);
        push_pixel(16'd0, 1'b1);
        push_pixel(16'd1234, 1'b0);
        push_pixel(16'd500, 1'b1);
        push_pixel(16'd5000, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'd50, 1'b0);
        push_pixel(16'd100, 1'b0);
        push_pixel(16'd6554, 1'b0);
        push_pixel(16'd1, 1'b0);
        push_pixel(16'd400, 1'b0);
        push_pixel(16'd7, 1'b0);
        push_pixel(16'd9, 1'b0);
        push_pixel(16'hFFFF, 1'b0);

        write_width('1);
        stream_rows(16, 1'b0);
        write_width(CFG_W'(DEF_MAX_WIDTH + 1));
        stream_rows(8, 1'b0);

        // narrow the row while the column position is past the new width
        write_width(CFG_W'(6));
        need_frame = 1'b1;
        stream_rows(6 * 9 + 4, 1'b0);
        write_width(CFG_W'(3));
        stream_rows(20, 1'b0);

        rand_count = 0;
        while (rand_count < 30) begin
            case ($urandom_range(0, 9))
                0: w = CFG_W'($urandom_range(17, 96));
                1: w = '0;
                default: w = CFG_W'($urandom_range(1, 12));
            endcase
            n = $urandom_range(40, 110);
            write_width(w);
            stream_rows(n, 1'b1);
            rand_count += n;
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("Summary: %0d pixel requests, %0d results checked, %0d width writes",
                 sent_count, checked, width_writes);
        $display("Covered reset width, zero and oversized widths, mid-row narrowing, %s",
                 "frame restarts and a long output hold");
        if (fail_total == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: vertical_pixel_ratio_filter.f
rtl/core/vprf_pkg.sv
rtl/core/vprf_divider.sv
rtl/core/vertical_pixel_ratio_filter.sv
verif/vprf_checker.sv
verif/vertical_pixel_ratio_filter_test.sv
